### hw/rtl/wsr_pkg.sv
// wsr_pkg: widths, types and constants shared by the weno5 slope pipeline
// no dependencies; imported by wsr_comp, wsr_qdiv and the top level
package wsr_pkg;

    // stencil cells after the optional pre-shift
    localparam int CELL_W      = 32;
    localparam int HALF_W      = 31;

    // difference terms and smoothness indicators
    localparam int TERM_W      = 36;
    localparam int MAG_W       = 35;
    localparam int TERM_BITS   = 29;
    localparam int TQ_W        = 29;
    localparam int SQ_W        = 58;
    localparam int EW          = 63;
    localparam int BETA_BITS   = 14;

    // weight products and their normalized sum
    localparam int PR_W        = 28;
    localparam int PQ_W        = 56;
    localparam int PW          = 59;
    localparam int SW          = 61;
    localparam int SUM_BITS    = 32;

    // nonlinear weight divider
    localparam int WEIGHT_BITS = 26;
    localparam int WQ_W        = WEIGHT_BITS + 1;
    localparam int WREM_W      = 32;
    localparam int WSTEPS      = 3;
    localparam int WSTAGES     = WQ_W / WSTEPS;

    // candidate delay and per-component latency
    localparam int G_DLY       = 12 + WSTAGES;
    localparam int COMP_LAT    = G_DLY + 2;

    // blended numerator and final scaled divider
    localparam int N_W         = 64;
    localparam int D6_W        = 34;
    localparam int D_W         = D6_W + WEIGHT_BITS;
    localparam int QSTEPS      = 2;

    typedef logic signed [CELL_W-1:0] t_cell;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [N_W-1:0]    t_num;

    typedef struct packed {
        t_cell far_l;
        t_cell near_l;
        t_cell centre;
        t_cell near_r;
        t_cell far_r;
    } t_stencil;

    typedef struct packed {
        t_term g0;
        t_term g1;
        t_term g2;
    } t_gset;

endpackage

### hw/rtl/weno5_slope_reconstruction.sv
// weno5_slope_reconstruction: two-component weno5 interface slope, one item per cycle when not stalled
// throughput: one item per cycle while no stall is held; the slope divider with two quotient bits per stage
// sets the depth that follows VALUE_WIDTH, the weight divider and the indicator chain add their own stages
// a stall at the output freezes every stage; nothing is lost or repeated
// reset (synchronous, active low) clears the valid bits only
module weno5_slope_reconstruction import wsr_pkg::*; #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_far_left_x,
    input  logic signed [VALUE_WIDTH-1:0] i_far_left_y,
    input  logic signed [VALUE_WIDTH-1:0] i_near_left_x,
    input  logic signed [VALUE_WIDTH-1:0] i_near_left_y,
    input  logic signed [VALUE_WIDTH-1:0] i_centre_x,
    input  logic signed [VALUE_WIDTH-1:0] i_centre_y,
    input  logic signed [VALUE_WIDTH-1:0] i_near_right_x,
    input  logic signed [VALUE_WIDTH-1:0] i_near_right_y,
    input  logic signed [VALUE_WIDTH-1:0] i_far_right_x,
    input  logic signed [VALUE_WIDTH-1:0] i_far_right_y,
    input  logic [HALF_W-1:0]             i_half_width,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_slope_x,
    output logic signed [VALUE_WIDTH-1:0] o_slope_y
);

    localparam int PRE  = (VALUE_WIDTH > CELL_W) ? VALUE_WIDTH - CELL_W : 0;
    localparam int XW   = (VALUE_WIDTH > CELL_W) ? VALUE_WIDTH : CELL_W;
    localparam int QLAT = (VALUE_WIDTH + QSTEPS - 1) / QSTEPS + 3;
    localparam int LAT  = COMP_LAT + QLAT + 1;

    // wide cells are cut back to 32 bits, narrow ones sign extended
    function automatic t_cell pre_cell(input logic [VALUE_WIDTH-1:0] v);
        logic signed [XW-1:0] x;
        x = XW'($signed(v));
        x = x >>> PRE;
        return x[CELL_W-1:0];
    endfunction

    // global advance: the whole pipe moves unless a finished item is held
    logic en;
    logic r_vld [LAT];

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // input register
    t_stencil r_cx;
    t_stencil r_cy;
    logic [HALF_W-1:0] r_hd [COMP_LAT+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx.far_l  <= pre_cell(i_far_left_x);
            r_cx.near_l <= pre_cell(i_near_left_x);
            r_cx.centre <= pre_cell(i_centre_x);
            r_cx.near_r <= pre_cell(i_near_right_x);
            r_cx.far_r  <= pre_cell(i_far_right_x);
            r_cy.far_l  <= pre_cell(i_far_left_y);
            r_cy.near_l <= pre_cell(i_near_left_y);
            r_cy.centre <= pre_cell(i_centre_y);
            r_cy.near_r <= pre_cell(i_near_right_y);
            r_cy.far_r  <= pre_cell(i_far_right_y);
            r_hd[0]     <= i_half_width;
            for (int k = 1; k <= COMP_LAT; k++) r_hd[k] <= r_hd[k-1];
        end
    end

    // per-component indicators, weights and blend
    t_num num_x;
    t_num num_y;

    wsr_comp u_comp_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cells (r_cx),
        .o_num   (num_x)
    );

    wsr_comp u_comp_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cells (r_cy),
        .o_num   (num_y)
    );

    // slope division; its last register is the output register
    wsr_qdiv #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_qdiv_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (num_x),
        .i_half  (r_hd[COMP_LAT]),
        .o_slope (o_slope_x)
    );

    wsr_qdiv #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_qdiv_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (num_y),
        .i_half  (r_hd[COMP_LAT]),
        .o_slope (o_slope_y)
    );

`ifndef SYNTH
    // backpressure only comes from a held result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    // an accepted item enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item missing from first stage");

    // a held result freezes the pipe end
    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_vld[LAT-2])))
        else $error("pipe moved under a held result");

    // items advance one stage per enabled cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && en) |=> r_vld[1])
        else $error("item dropped between stages");
`endif

endmodule

### hw/rtl/wsr_comp.sv
// wsr_comp: one component of the weno5 reconstruction, stencil in, blended numerator out
// indicators, weight normalization, pipelined weight division and candidate blend
// depends on wsr_pkg
module wsr_comp import wsr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_stencil i_cells,
    output t_num     o_num
);

    localparam logic [WQ_W-1:0] W_ONE = {1'b1, {WEIGHT_BITS{1'b0}}};

    function automatic logic [2:0] shift_terms(input logic [MAG_W-1:0] m);
        logic [2:0] s;
        s = '0;
        for (int k = TERM_BITS; k < MAG_W; k++) begin
            if (m[k]) s = 3'(k - TERM_BITS + 1);
        end
        return s;
    endfunction

    function automatic logic [5:0] shift_beta(input logic [EW-1:0] m);
        logic [5:0] s;
        s = '0;
        for (int k = BETA_BITS; k < EW; k++) begin
            if (m[k]) s = 6'(k - BETA_BITS + 1);
        end
        return s;
    endfunction

    function automatic logic [4:0] shift_sum(input logic [SW-1:0] m);
        logic [4:0] s;
        s = '0;
        for (int k = SUM_BITS; k < SW; k++) begin
            if (m[k]) s = 5'(k - SUM_BITS + 1);
        end
        return s;
    endfunction

    // stage 1: difference terms, their magnitudes and the candidate offsets
    t_term a, b, c, d, e;
    t_term t [6];
    logic [MAG_W-1:0] n_qm [6];
    logic [MAG_W-1:0] r_qm [6];
    t_gset n_g;
    t_gset r_gd [G_DLY];

    always_comb begin
        a = TERM_W'(i_cells.far_l);
        b = TERM_W'(i_cells.near_l);
        c = TERM_W'(i_cells.centre);
        d = TERM_W'(i_cells.near_r);
        e = TERM_W'(i_cells.far_r);
        t[0] = a - (b <<< 1) + c;
        t[1] = a - (b <<< 2) + (c <<< 1) + c;
        t[2] = b - (c <<< 1) + d;
        t[3] = b - d;
        t[4] = c - (d <<< 1) + e;
        t[5] = (c <<< 1) + c - (d <<< 2) + e;
        for (int k = 0; k < 6; k++) begin
            n_qm[k] = t[k][TERM_W-1] ? MAG_W'(-t[k]) : MAG_W'(t[k]);
        end
        n_g.g0 = (a <<< 1) - (b <<< 3) + b + (c <<< 2) + c;
        n_g.g1 = (d <<< 1) - b - c;
        n_g.g2 = (d <<< 2) + d - (c <<< 2) - e;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qm <= n_qm;
        end
    end

    // candidate offsets ride along until the blend
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gd[0] <= n_g;
            for (int k = 1; k < G_DLY; k++) r_gd[k] <= r_gd[k-1];
        end
    end

    // stage 2: common shift so every term fits the squaring width
    logic [MAG_W-1:0] qm_or;
    logic [2:0]       s1;
    logic [TQ_W-1:0]  n_q [6];
    logic [TQ_W-1:0]  r_q [6];

    always_comb begin
        qm_or = '0;
        for (int k = 0; k < 6; k++) qm_or = qm_or | r_qm[k];
        s1 = shift_terms(qm_or);
        for (int k = 0; k < 6; k++) n_q[k] = TQ_W'(r_qm[k] >> s1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_q <= n_q;
    end

    // stage 3: squares of the scaled terms
    logic [SQ_W-1:0] r_sq [6];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) r_sq[k] <= SQ_W'(r_q[k]) * SQ_W'(r_q[k]);
        end
    end

    // stage 4: indicators times twelve, plus one lsb of epsilon
    logic [EW-1:0] r_ebig [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_ebig[k] <= EW'(r_sq[2*k]) * EW'(13) + EW'(r_sq[2*k+1]) * EW'(3) + EW'(1);
            end
        end
    end

    // stage 5: find the shift that brings the indicators to 14 bits
    logic [EW-1:0] e_or;
    logic [EW-1:0] r_ebig2 [3];
    logic [5:0]    r_s2;

    always_comb begin
        e_or = r_ebig[0] | r_ebig[1] | r_ebig[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ebig2 <= r_ebig;
            r_s2    <= shift_beta(e_or);
        end
    end

    // stage 6: scaled indicators, never zero
    logic [BETA_BITS-1:0] n_e [3];
    logic [BETA_BITS-1:0] r_e [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_e[k] = BETA_BITS'(r_ebig2[k] >> r_s2);
            if (n_e[k] == '0) n_e[k] = BETA_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_e <= n_e;
    end

    // stage 7: pairwise products of the indicators
    logic [PR_W-1:0] r_pr [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pr[0] <= PR_W'(r_e[1]) * PR_W'(r_e[2]);
            r_pr[1] <= PR_W'(r_e[0]) * PR_W'(r_e[2]);
            r_pr[2] <= PR_W'(r_e[0]) * PR_W'(r_e[1]);
        end
    end

    // stage 8: squared products
    logic [PQ_W-1:0] r_pq [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) r_pq[k] <= PQ_W'(r_pr[k]) * PQ_W'(r_pr[k]);
        end
    end

    // stage 9: apply ideal weights 1:6:3 and sum
    logic [PW-1:0] n_p [3];
    logic [PW-1:0] r_p [3];
    logic [SW-1:0] r_psum;

    always_comb begin
        n_p[0] = PW'(r_pq[0]);
        n_p[1] = PW'(r_pq[1]) * PW'(6);
        n_p[2] = PW'(r_pq[2]) * PW'(3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= n_p;
            r_psum <= SW'(n_p[0]) + SW'(n_p[1]) + SW'(n_p[2]);
        end
    end

    // stage 10: shift that brings the weight sum under 32 bits
    logic [PW-1:0] r_p2 [3];
    logic [4:0]    r_s3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2 <= r_p;
            r_s3 <= shift_sum(r_psum);
        end
    end

    // stage 11 and divider stages: w0 and w1 as fractions of 2^26, one row per stage
    logic [SUM_BITS-1:0] ps [3];
    logic [SUM_BITS+1:0] tsum;
    logic [WREM_W-1:0]   n_wden [WSTAGES+1];
    logic [WREM_W-1:0]   r_wden [WSTAGES+1];
    logic [WREM_W-1:0]   n_wrem [WSTAGES+1][2];
    logic [WREM_W-1:0]   r_wrem [WSTAGES+1][2];
    logic [WQ_W-1:0]     n_wlo  [WSTAGES+1][2];
    logic [WQ_W-1:0]     r_wlo  [WSTAGES+1][2];
    logic [WQ_W-1:0]     n_wq   [WSTAGES+1][2];
    logic [WQ_W-1:0]     r_wq   [WSTAGES+1][2];

    always_comb begin
        logic [WREM_W:0]   rs;
        logic [WREM_W-1:0] rem;
        logic [WQ_W-1:0]   lo;
        logic [WQ_W-1:0]   q;
        for (int k = 0; k < 3; k++) ps[k] = SUM_BITS'(r_p2[k] >> r_s3);
        tsum = (SUM_BITS+2)'(ps[0]) + (SUM_BITS+2)'(ps[1]) + (SUM_BITS+2)'(ps[2]);
        n_wden[0] = WREM_W'(tsum);
        if (n_wden[0] == '0) n_wden[0] = WREM_W'(1);
        for (int u = 0; u < 2; u++) begin
            n_wrem[0][u] = {1'b0, ps[u][SUM_BITS-1:1]};
            n_wlo[0][u]  = {ps[u][0], {WEIGHT_BITS{1'b0}}};
            n_wq[0][u]   = '0;
        end
        // restoring division rows
        for (int st = 1; st <= WSTAGES; st++) begin
            n_wden[st] = r_wden[st-1];
            for (int u = 0; u < 2; u++) begin
                rem = r_wrem[st-1][u];
                lo  = r_wlo[st-1][u];
                q   = r_wq[st-1][u];
                for (int i = 0; i < WSTEPS; i++) begin
                    rs = {rem, lo[WQ_W-1]};
                    lo = {lo[WQ_W-2:0], 1'b0};
                    if (rs >= {1'b0, r_wden[st-1]}) begin
                        rs = rs - {1'b0, r_wden[st-1]};
                        q  = {q[WQ_W-2:0], 1'b1};
                    end else begin
                        q  = {q[WQ_W-2:0], 1'b0};
                    end
                    rem = rs[WREM_W-1:0];
                end
                n_wrem[st][u] = rem;
                n_wlo[st][u]  = lo;
                n_wq[st][u]   = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wden <= n_wden;
            r_wrem <= n_wrem;
            r_wlo  <= n_wlo;
            r_wq   <= n_wq;
        end
    end

    // stage 12: third weight takes what is left of 2^26
    logic [WQ_W-1:0] r_w [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w[0] <= r_wq[WSTAGES][0];
            r_w[1] <= r_wq[WSTAGES][1];
            r_w[2] <= W_ONE - r_wq[WSTAGES][0] - r_wq[WSTAGES][1];
        end
    end

    // stage 13: weight times candidate offset
    t_num r_prod [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[0] <= t_num'($signed({1'b0, r_w[0]})) * t_num'(r_gd[G_DLY-1].g0);
            r_prod[1] <= t_num'($signed({1'b0, r_w[1]})) * t_num'(r_gd[G_DLY-1].g1);
            r_prod[2] <= t_num'($signed({1'b0, r_w[2]})) * t_num'(r_gd[G_DLY-1].g2);
        end
    end

    // stage 14: blended numerator
    t_num r_num;

    always_ff @(posedge i_clk) begin
        if (i_en) r_num <= r_prod[0] + r_prod[1] + r_prod[2];
    end

    assign o_num = r_num;

endmodule

### hw/rtl/wsr_qdiv.sv
// wsr_qdiv: scaled, saturating division of the blended numerator by 6 * 2^26 * half width
// pipelined restoring divider, QSTEPS quotient bits per stage
// depends on wsr_pkg
module wsr_qdiv import wsr_pkg::*; #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  t_num                          i_num,
    input  logic [HALF_W-1:0]             i_half,
    output logic signed [VALUE_WIDTH-1:0] o_slope
);

    localparam int PRE     = (VALUE_WIDTH > CELL_W) ? VALUE_WIDTH - CELL_W : 0;
    localparam int SCALE   = FRAC_BITS + PRE;
    localparam int DVW     = N_W + SCALE;
    localparam int TOPW    = DVW - VALUE_WIDTH;
    localparam int CMPW    = (TOPW > D_W) ? TOPW : D_W;
    localparam int QSTAGES = (VALUE_WIDTH + QSTEPS - 1) / QSTEPS;
    localparam logic [VALUE_WIDTH-1:0] SAT_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] SAT_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // first stage: magnitude, sign and divisor
    logic [N_W-1:0]  r_m;
    logic            r_neg;
    logic            r_zero;
    logic [D_W-1:0]  r_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= i_num[N_W-1] ? N_W'(-i_num) : N_W'(i_num);
            r_neg  <= i_num[N_W-1];
            r_zero <= (i_num == '0);
            r_d    <= {D6_W'(i_half) * D6_W'(6), {WEIGHT_BITS{1'b0}}};
        end
    end

    // second stage forms the top remainder and overflow, then one row per stage
    logic [DVW-1:0]         dv;
    logic [CMPW-1:0]        top_x;
    logic [CMPW-1:0]        d_x;
    logic [D_W-1:0]         n_rem  [QSTAGES+1];
    logic [D_W-1:0]         r_rem  [QSTAGES+1];
    logic [D_W-1:0]         n_den  [QSTAGES+1];
    logic [D_W-1:0]         r_den  [QSTAGES+1];
    logic [VALUE_WIDTH-1:0] n_lo   [QSTAGES+1];
    logic [VALUE_WIDTH-1:0] r_lo   [QSTAGES+1];
    logic [VALUE_WIDTH-1:0] n_q    [QSTAGES+1];
    logic [VALUE_WIDTH-1:0] r_q    [QSTAGES+1];
    logic                   n_neg  [QSTAGES+1];
    logic                   r_neg2 [QSTAGES+1];
    logic                   n_zero [QSTAGES+1];
    logic                   r_zero2[QSTAGES+1];
    logic                   n_ovf  [QSTAGES+1];
    logic                   r_ovf  [QSTAGES+1];

    always_comb begin
        logic [D_W:0]           rs;
        logic [D_W-1:0]         rem;
        logic [VALUE_WIDTH-1:0] lo;
        logic [VALUE_WIDTH-1:0] q;
        dv    = {r_m, {SCALE{1'b0}}};
        top_x = CMPW'(dv[DVW-1:VALUE_WIDTH]);
        d_x   = CMPW'(r_d);
        n_ovf[0]  = (top_x >= d_x);
        n_rem[0]  = top_x[D_W-1:0];
        n_den[0]  = r_d;
        n_lo[0]   = dv[VALUE_WIDTH-1:0];
        n_q[0]    = '0;
        n_neg[0]  = r_neg;
        n_zero[0] = r_zero;
        for (int st = 1; st <= QSTAGES; st++) begin
            rem = r_rem[st-1];
            lo  = r_lo[st-1];
            q   = r_q[st-1];
            for (int i = 0; i < QSTEPS; i++) begin
                // the last row may carry fewer bits than QSTEPS
                if ((st - 1) * QSTEPS + i < VALUE_WIDTH) begin
                    rs = {rem, lo[VALUE_WIDTH-1]};
                    lo = lo << 1;
                    if (rs >= {1'b0, r_den[st-1]}) begin
                        rs = rs - {1'b0, r_den[st-1]};
                        q  = {q[VALUE_WIDTH-2:0], 1'b1};
                    end else begin
                        q  = {q[VALUE_WIDTH-2:0], 1'b0};
                    end
                    rem = rs[D_W-1:0];
                end
            end
            n_rem[st]  = rem;
            n_lo[st]   = lo;
            n_q[st]    = q;
            n_den[st]  = r_den[st-1];
            n_neg[st]  = r_neg2[st-1];
            n_zero[st] = r_zero2[st-1];
            n_ovf[st]  = r_ovf[st-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= n_rem;
            r_den   <= n_den;
            r_lo    <= n_lo;
            r_q     <= n_q;
            r_neg2  <= n_neg;
            r_zero2 <= n_zero;
            r_ovf   <= n_ovf;
        end
    end

    // sign and saturation
    logic [VALUE_WIDTH-1:0] n_slope;
    logic [VALUE_WIDTH-1:0] r_slope;
    logic [VALUE_WIDTH-1:0] qf;

    always_comb begin
        qf = r_q[QSTAGES];
        if (r_zero2[QSTAGES]) begin
            n_slope = '0;
        end else if (r_neg2[QSTAGES]) begin
            n_slope = (r_ovf[QSTAGES] || qf > SAT_MIN) ? SAT_MIN : VALUE_WIDTH'(0) - qf;
        end else begin
            n_slope = (r_ovf[QSTAGES] || qf > SAT_MAX) ? SAT_MAX : qf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_slope <= n_slope;
    end

    assign o_slope = $signed(r_slope);

endmodule
